// File: hdl/rhdc_pkg.sv
// Shared constants, payload types and control structs for the RGB histogram block
package rhdc_pkg;

    localparam int COUNT_BITS = 24;
    localparam int LEVELS     = 256;
    localparam int VAL_W      = 8;
    localparam int IDX_W      = $clog2(LEVELS);
    localparam int GCNT_W     = IDX_W + 1;
    localparam int GRP_W      = COUNT_BITS + IDX_W;
    localparam int SUM_W      = COUNT_BITS + IDX_W + VAL_W;
    localparam int Q_W        = VAL_W;
    localparam int ISUM_W     = 2 * IDX_W;
    localparam int PKN_W      = IDX_W + 1;
    localparam int REC_W      = 2 * VAL_W;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ROUNDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 1'd1;

    // divider job codes
    localparam logic [1:0] DIV_MEAN  = 2'd0;
    localparam logic [1:0] DIV_ROUND = 2'd1;
    localparam logic [1:0] DIV_FINAL = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] red_value;
        logic [VAL_W-1:0] green_value;
        logic [VAL_W-1:0] blue_value;
        logic             last_pixel;
    } pix_t;

    typedef struct packed {
        logic [VAL_W-1:0] dominant_red;
        logic [VAL_W-1:0] dominant_green;
        logic [VAL_W-1:0] dominant_blue;
        logic [VAL_W-1:0] mean_red;
        logic [VAL_W-1:0] mean_green;
        logic [VAL_W-1:0] mean_blue;
        logic             empty_region;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic             px_load;
        logic             inc_wr;
        logic             hist_clr;
        logic             sweep;
        logic             grp_rd;
        logic             grp_zero;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] rnd;
        logic             clr_acc;
        logic             rnd_init;
        logic             div_start;
        logic [1:0]       div_sel;
        logic             load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic grp_last;
        logic rnd_last;
        logic div_done;
        logic out_free;
    } sts_t;

    // datapath to each channel lane
    typedef struct packed {
        cmd_t             cmd;
        logic             sw_vld;
        logic [IDX_W-1:0] sw_idx;
        logic             grp_close;
        logic [IDX_W-1:0] grp_idx;
        logic             g_vld;
        logic             g_zero;
        logic [IDX_W-1:0] g_idx;
    } lane_ctl_t;

endpackage

// File: hdl/rhdc_div.sv
// Restoring divider producing an 8-bit quotient, one bit per cycle
module rhdc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rhdc_pkg::SUM_W-1:0] dividend,
    input  logic [rhdc_pkg::GRP_W-1:0] divisor,
    output logic                      done,
    output logic [rhdc_pkg::Q_W-1:0]  quot
);
    import rhdc_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] dvs_reg;
    logic [Q_W-1:0]   quot_reg;

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // trial subtract, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dvs_reg  <= SUM_W'({divisor, {(Q_W-1){1'b0}}});
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_reg  <= rem_reg - dvs_reg;
                quot_reg <= {quot_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[Q_W-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: hdl/rhdc_lane.sv
// One color channel: histogram memory, group memory, peak search and mean
module rhdc_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rhdc_pkg::lane_ctl_t        ctl,
    input  logic [rhdc_pkg::VAL_W-1:0] pix,
    input  logic [rhdc_pkg::VAL_W-1:0] bin_w,
    input  logic [rhdc_pkg::VAL_W-1:0] peak_r,
    output logic [rhdc_pkg::VAL_W-1:0] mean_val,
    output logic [rhdc_pkg::VAL_W-1:0] dom_val,
    output logic                       tot_zero,
    output logic                       div_done
);
    import rhdc_pkg::*;

    logic [COUNT_BITS-1:0] hist_mem [LEVELS];
    logic [COUNT_BITS-1:0] hist_q_reg;
    logic [IDX_W-1:0]      hist_rd_addr;
    logic [IDX_W-1:0]      hist_wr_addr;
    logic [COUNT_BITS-1:0] hist_wd;
    logic                  hist_we;
    logic [IDX_W-1:0]      px_reg;
    logic [COUNT_BITS-1:0] hist_inc;

    logic [GRP_W-1:0]      grp_mem [LEVELS];
    logic [GRP_W-1:0]      grp_q_reg;
    logic [IDX_W-1:0]      grp_wr_addr;
    logic [GRP_W-1:0]      grp_wd;
    logic                  grp_we;
    logic                  grp_hit;

    logic [GRP_W-1:0]      acc_reg;
    logic [GRP_W-1:0]      grp_sum;
    logic [SUM_W-1:0]      sum_reg;
    logic [GRP_W-1:0]      tot_reg;
    logic [GRP_W-1:0]      prod;
    logic [GRP_W-1:0]      mx_reg;
    logic [ISUM_W-1:0]     isum_reg;
    logic [PKN_W-1:0]      pkn_reg;
    logic [REC_W-1:0]      rec_reg;
    logic [VAL_W-1:0]      mean_reg;
    logic [VAL_W-1:0]      dom_reg;
    logic [1:0]            sel_reg;

    logic [SUM_W-1:0]      dvd;
    logic [GRP_W-1:0]      dvs;
    logic                  done;
    logic [Q_W-1:0]        quot;
    logic [2*VAL_W-1:0]    dom_full;

    // histogram port: read at incoming pixel or sweep index, write increment or clear
    assign hist_inc = (hist_q_reg == COUNT_MAX) ? hist_q_reg : hist_q_reg + 1'b1;

    always_comb
    begin
        hist_rd_addr = ctl.cmd.sweep ? ctl.cmd.idx : pix;
        hist_we      = 1'b0;
        hist_wr_addr = px_reg;
        hist_wd      = hist_inc;
        if (ctl.cmd.hist_clr)
        begin
            hist_we      = 1'b1;
            hist_wr_addr = ctl.cmd.idx;
            hist_wd      = '0;
        end
        else if (ctl.cmd.inc_wr)
        begin
            hist_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wr_addr] <= hist_wd;
        end
        hist_q_reg <= hist_mem[hist_rd_addr];
    end

    // hold pixel value for the write-back cycle
    always_ff @(posedge clk)
    begin
        if (ctl.cmd.px_load)
        begin
            px_reg <= pix;
        end
    end

    // group memory: filled during sweep, peaks zeroed during each round
    assign grp_sum = acc_reg + GRP_W'(hist_q_reg);
    assign grp_hit = ctl.g_vld && ctl.g_zero && (grp_q_reg == mx_reg);

    always_comb
    begin
        grp_we      = 1'b0;
        grp_wr_addr = ctl.g_idx;
        grp_wd      = '0;
        if (ctl.sw_vld && ctl.grp_close)
        begin
            grp_we      = 1'b1;
            grp_wr_addr = ctl.grp_idx;
            grp_wd      = grp_sum;
        end
        else if (grp_hit)
        begin
            grp_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_we)
        begin
            grp_mem[grp_wr_addr] <= grp_wd;
        end
        grp_q_reg <= grp_mem[ctl.cmd.idx];
    end

    // divider operand selection
    always_comb
    begin
        case (ctl.cmd.div_sel)
            DIV_ROUND:
            begin
                dvd = SUM_W'(isum_reg);
                dvs = GRP_W'(pkn_reg);
            end
            DIV_FINAL:
            begin
                dvd = SUM_W'(rec_reg);
                dvs = GRP_W'(peak_r);
            end
            default:
            begin
                dvd = sum_reg;
                dvs = tot_reg;
            end
        endcase
    end

    rhdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (done),
        .quot     (quot)
    );

    assign prod     = GRP_W'(hist_q_reg) * GRP_W'(ctl.sw_idx);
    assign dom_full = quot * bin_w;

    // accumulate sums, track peaks and collect divider results
    always_ff @(posedge clk)
    begin
        if (ctl.cmd.clr_acc)
        begin
            acc_reg <= '0;
            sum_reg <= '0;
            tot_reg <= '0;
            rec_reg <= '0;
        end
        else
        begin
            if (ctl.sw_vld)
            begin
                acc_reg <= ctl.grp_close ? '0 : grp_sum;
                sum_reg <= sum_reg + SUM_W'(prod);
                tot_reg <= tot_reg + GRP_W'(hist_q_reg);
            end
            if (done && (sel_reg == DIV_ROUND))
            begin
                rec_reg <= rec_reg + REC_W'(quot);
            end
        end

        if (ctl.cmd.rnd_init)
        begin
            mx_reg   <= '0;
            isum_reg <= '0;
            pkn_reg  <= '0;
        end
        else if (ctl.g_vld && !ctl.g_zero)
        begin
            if (grp_q_reg > mx_reg)
            begin
                mx_reg <= grp_q_reg;
            end
        end
        else if (grp_hit)
        begin
            isum_reg <= isum_reg + ISUM_W'(ctl.g_idx);
            pkn_reg  <= pkn_reg + 1'b1;
        end

        if (ctl.cmd.div_start)
        begin
            sel_reg <= ctl.cmd.div_sel;
        end

        if (done && (sel_reg == DIV_MEAN))
        begin
            mean_reg <= quot;
        end
        if (done && (sel_reg == DIV_FINAL))
        begin
            dom_reg <= dom_full[VAL_W-1:0];
        end
    end

    assign mean_val = mean_reg;
    assign dom_val  = dom_reg;
    assign tot_zero = (tot_reg == '0);
    assign div_done = done;

    // a round division always has at least one peak group to divide by
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd.div_start && (ctl.cmd.div_sel == DIV_ROUND)) |-> (pkn_reg != '0))
        else $error("round division started with no peak groups");

endmodule

// File: hdl/rhdc_datapath.sv
// Datapath: configuration, sweep bookkeeping, three channel lanes, result register
module rhdc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rhdc_pkg::cmd_t                 cmd,
    output rhdc_pkg::sts_t                 sts,
    input  rhdc_pkg::pix_t                 in_data,
    input  logic                           cfg_we,
    input  logic [rhdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhdc_pkg::CFG_W-1:0]     cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rhdc_pkg::res_t                 out_data
);
    import rhdc_pkg::*;

    logic [VAL_W-1:0]  peak_rounds_reg;
    logic [VAL_W-1:0]  bin_width_reg;
    logic [VAL_W-1:0]  peak_eff;
    logic [VAL_W-1:0]  bin_eff;

    logic              sw_vld_reg;
    logic [IDX_W-1:0]  sw_idx_reg;
    logic              g_vld_reg;
    logic              g_zero_reg;
    logic [IDX_W-1:0]  g_idx_reg;
    logic [GCNT_W-1:0] g_reg;
    logic [VAL_W-1:0]  cnt_reg;
    logic [GCNT_W-1:0] g_m1;
    logic              grp_close;

    lane_ctl_t         lctl;
    logic [VAL_W-1:0]  mean_r, mean_g, mean_b;
    logic [VAL_W-1:0]  dom_r, dom_g, dom_b;
    logic              zero_r, zero_g, zero_b;
    logic              done_r, done_g, done_b;
    logic              empty;

    logic              out_valid_reg;
    res_t              out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_rounds_reg <= VAL_W'(1);
            bin_width_reg   <= VAL_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEAK_ROUNDS: peak_rounds_reg <= cfg_data[VAL_W-1:0];
                CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data[VAL_W-1:0];
                default:         ;
            endcase
        end
    end

    // zero acts as one
    assign peak_eff = (peak_rounds_reg == '0) ? VAL_W'(1) : peak_rounds_reg;
    assign bin_eff  = (bin_width_reg == '0) ? VAL_W'(1) : bin_width_reg;

    // delay read commands to line up with registered memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_vld_reg <= 1'b0;
            g_vld_reg  <= 1'b0;
            g_zero_reg <= 1'b0;
        end
        else
        begin
            sw_vld_reg <= cmd.sweep;
            g_vld_reg  <= cmd.grp_rd;
            g_zero_reg <= cmd.grp_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_idx_reg <= cmd.idx;
        g_idx_reg  <= cmd.idx;
    end

    // group boundaries: close on a full group or on the top level
    assign grp_close = (cnt_reg == bin_eff - 1'b1) || (sw_idx_reg == IDX_W'(LEVELS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
        begin
            g_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (sw_vld_reg)
        begin
            if (grp_close)
            begin
                g_reg   <= g_reg + 1'b1;
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign g_m1 = g_reg - 1'b1;

    always_comb
    begin
        lctl.cmd       = cmd;
        lctl.sw_vld    = sw_vld_reg;
        lctl.sw_idx    = sw_idx_reg;
        lctl.grp_close = grp_close;
        lctl.grp_idx   = g_reg[IDX_W-1:0];
        lctl.g_vld     = g_vld_reg;
        lctl.g_zero    = g_zero_reg;
        lctl.g_idx     = g_idx_reg;
    end

    rhdc_lane u_lane_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lctl),
        .pix      (in_data.red_value),
        .bin_w    (bin_eff),
        .peak_r   (peak_eff),
        .mean_val (mean_r),
        .dom_val  (dom_r),
        .tot_zero (zero_r),
        .div_done (done_r)
    );

    rhdc_lane u_lane_g (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lctl),
        .pix      (in_data.green_value),
        .bin_w    (bin_eff),
        .peak_r   (peak_eff),
        .mean_val (mean_g),
        .dom_val  (dom_g),
        .tot_zero (zero_g),
        .div_done (done_g)
    );

    rhdc_lane u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lctl),
        .pix      (in_data.blue_value),
        .bin_w    (bin_eff),
        .peak_r   (peak_eff),
        .mean_val (mean_b),
        .dom_val  (dom_b),
        .tot_zero (zero_b),
        .div_done (done_b)
    );

    assign empty = zero_r || zero_g || zero_b;

    // status back to the controller; lanes run in lockstep
    always_comb
    begin
        sts.grp_last = (cmd.idx == g_m1[IDX_W-1:0]);
        sts.rnd_last = (cmd.rnd == peak_eff - 1'b1);
        sts.div_done = done_r && done_g && done_b;
        sts.out_free = !out_valid_reg || out_ready;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.dominant_red   <= dom_r;
            out_data_reg.dominant_green <= dom_g;
            out_data_reg.dominant_blue  <= dom_b;
            out_data_reg.mean_red       <= empty ? '0 : mean_r;
            out_data_reg.mean_green     <= empty ? '0 : mean_g;
            out_data_reg.mean_blue      <= empty ? '0 : mean_b;
            out_data_reg.empty_region   <= empty;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a new result never overwrites one that has not been transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transfer");

endmodule

// File: hdl/rhdc_ctrl.sv
// Controller: sequences pixel updates, the region sweep and the peak rounds
module rhdc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           last_pixel,
    input  rhdc_pkg::sts_t sts,
    output rhdc_pkg::cmd_t cmd
);
    import rhdc_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_WR     = 5'd2;
    localparam logic [4:0] S_SWEEP  = 5'd3;
    localparam logic [4:0] S_SDRAIN = 5'd4;
    localparam logic [4:0] S_MSTART = 5'd5;
    localparam logic [4:0] S_MDIV   = 5'd6;
    localparam logic [4:0] S_RINIT  = 5'd7;
    localparam logic [4:0] S_MAX    = 5'd8;
    localparam logic [4:0] S_ZERO   = 5'd9;
    localparam logic [4:0] S_ZDRAIN = 5'd10;
    localparam logic [4:0] S_RSTART = 5'd11;
    localparam logic [4:0] S_RDIV   = 5'd12;
    localparam logic [4:0] S_FSTART = 5'd13;
    localparam logic [4:0] S_FDIV   = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    logic [4:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [VAL_W-1:0] rnd_reg, rnd_next;
    logic             last_reg, last_next;
    logic             accept;
    logic             idx_top;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign idx_top  = (idx_reg == IDX_W'(LEVELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            rnd_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rnd_reg   <= rnd_next;
            last_reg  <= last_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rnd_next   = rnd_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.rnd    = rnd_reg;
        cmd.div_sel = DIV_MEAN;

        case (state_reg)
            // clear all histogram entries after reset
            S_INIT:
            begin
                cmd.hist_clr = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_top)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.px_load = 1'b1;
                    last_next   = last_pixel;
                    state_next  = S_WR;
                end
            end
            // write back the incremented counts
            S_WR:
            begin
                cmd.inc_wr = 1'b1;
                if (last_reg)
                begin
                    cmd.clr_acc = 1'b1;
                    idx_next    = '0;
                    state_next  = S_SWEEP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            // read and clear every level, building groups and mean sums
            S_SWEEP:
            begin
                cmd.hist_clr = 1'b1;
                cmd.sweep    = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_top)
                begin
                    state_next = S_SDRAIN;
                end
            end
            S_SDRAIN:
            begin
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = S_MDIV;
            end
            S_MDIV:
            begin
                if (sts.div_done)
                begin
                    rnd_next   = '0;
                    state_next = S_RINIT;
                end
            end
            S_RINIT:
            begin
                cmd.rnd_init = 1'b1;
                idx_next     = '0;
                state_next   = S_MAX;
            end
            // find the largest group
            S_MAX:
            begin
                cmd.grp_rd = 1'b1;
                idx_next   = idx_reg + 1'b1;
                if (sts.grp_last)
                begin
                    idx_next   = '0;
                    state_next = S_ZERO;
                end
            end
            // collect and drop every group at the maximum
            S_ZERO:
            begin
                cmd.grp_rd   = 1'b1;
                cmd.grp_zero = 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (sts.grp_last)
                begin
                    state_next = S_ZDRAIN;
                end
            end
            S_ZDRAIN:
            begin
                state_next = S_RSTART;
            end
            S_RSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ROUND;
                state_next    = S_RDIV;
            end
            S_RDIV:
            begin
                if (sts.div_done)
                begin
                    if (sts.rnd_last)
                    begin
                        state_next = S_FSTART;
                    end
                    else
                    begin
                        rnd_next   = rnd_reg + 1'b1;
                        state_next = S_RINIT;
                    end
                end
            end
            S_FSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FINAL;
                state_next    = S_FDIV;
            end
            S_FDIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            // hand the result over once the output register is free
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    last_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // divider finishes only while a division phase waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |->
            (state_reg == S_MDIV || state_reg == S_RDIV || state_reg == S_FDIV))
        else $error("divider done outside a division phase");

    // the sweep always follows the write-back of a last pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && last_reg) |=> (state_reg == S_SWEEP && idx_reg == '0))
        else $error("sweep not started after last pixel");

    // pixels are only taken with no region computation in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !last_reg)
        else $error("pixel accepted during region computation");

endmodule

// File: hdl/rgb_histogram_dominant_color.sv
// Top level of the RGB region histogram with dominant and mean color
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+------------------------------
//  pixel   | in_valid in_ready in_data     | in_valid and in_ready high
//  result  | out_valid out_ready out_data  | out_valid and out_ready high
//  config  | cfg_we cfg_index cfg_data     | cfg_we high, no wait
//
// Each pixel is one histogram memory read and one write-back; the next pixel is
// taken after the write-back. After a last pixel the region pass runs the level
// sweep, the mean division, R peak rounds over G = ceil(256 / bin width) groups
// (a max scan, a zero scan and a round division each) and the final division.
// After reset a pass clears every histogram level; no pixel is taken then.
// A pending result does not stall the next region's pixels; a stalled result
// holds the next region's result until it has been transferred.
module rgb_histogram_dominant_color (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rhdc_pkg::pix_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rhdc_pkg::res_t                 out_data,
    input  logic                           cfg_we,
    input  logic [rhdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhdc_pkg::CFG_W-1:0]     cfg_data
);
    import rhdc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rhdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .last_pixel (in_data.last_pixel),
        .sts        (sts),
        .cmd        (cmd)
    );

    rhdc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
